// ===== src/sitrd_pkg.sv =====
// Types, constants and helpers shared by the radix digit converter.
package sitrd_pkg;

   localparam int WORD_W     = 32;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = 4;
   localparam int ALPHA_N    = 16;
   localparam int SIZE_W     = 5;
   localparam int ALPHA_W    = 64;
   localparam int DIGIT_BUF  = 32;
   localparam int DIGIT_IW   = $clog2(DIGIT_BUF);
   localparam int COUNT_W    = DIGIT_IW + 1;
   localparam int STEP_BITS  = 8;
   localparam int MIN_BASE   = 2;
   localparam int MAX_BASE   = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_SIZE  = 2'd0,
      CSR_ALPHA_LOW  = 2'd1,
      CSR_ALPHA_HIGH = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [SIZE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [WORD_W-1:0]  quotient;
      logic [DIGIT_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [CHAR_W-1:0] alpha_entry(
      input logic [ALPHA_W-1:0]  lo,
      input logic [ALPHA_W-1:0]  hi,
      input logic [DIGIT_W-1:0]  idx
   );
      logic [ALPHA_W-1:0] word;
      word = idx[DIGIT_W-1] ? hi : lo;
      return word[idx[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
   endfunction

endpackage

// ===== src/sitrd_div.sv =====
// Iterative 32-bit by 5-bit unsigned divider, several quotient bits per cycle.
module sitrd_div
   import sitrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CHUNKS  = WORD_W / STEP_BITS;
   localparam int CHUNK_W = $clog2(CHUNKS);
   localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(CHUNKS - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CHUNK_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0]   q_ff, q_in;
   logic [SIZE_W-1:0]   r_ff, r_in;
   logic [SIZE_W-1:0]   d_ff, d_in;

   always_comb begin
      logic [SIZE_W:0]   r_t;
      logic [WORD_W-1:0] q_t;
      r_t     = {1'b0, r_ff};
      q_t     = q_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      d_in    = d_ff;
      // restoring steps: dividend shifts out the top, quotient bits in the bottom
      for (int k = 0; k < STEP_BITS; k++) begin
         r_t = {r_t[SIZE_W-1:0], q_t[WORD_W-1]};
         q_t = {q_t[WORD_W-2:0], 1'b0};
         if (r_t >= {1'b0, d_ff}) begin
            r_t    = r_t - {1'b0, d_ff};
            q_t[0] = 1'b1;
         end
      end
      q_in = q_ff;
      r_in = r_ff;
      if (req.start) begin
         q_in    = req.dividend;
         r_in    = '0;
         d_in    = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = q_t;
         r_in   = r_t[SIZE_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_CHUNK) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = q_ff;
   assign rsp.remainder = r_ff[DIGIT_W-1:0];

`ifndef SYNTH
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without work");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> r_ff < d_ff)
      else $error("remainder not below divisor");
`endif

endmodule

// ===== src/signed_int_to_radix_digits_core.sv =====
// Top level: signed 32-bit number to radix text, one character word per cycle
// while the output is not stalled. The registered alphabet check comes first,
// then each digit from the divider, eight quotient bits at a time, then an
// optional minus sign and the characters, most significant first; a bad base
// gives a lone invalid word. One number at a time; the divider loop sets the rate.
// Reset is synchronous, active high, and clears the config registers, state,
// output valid and digit count (base invalid until configured).
module signed_int_to_radix_digits_core
   import sitrd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // config write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ALPHA_W-1:0]   csr_data,
   // input words
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [WORD_W-1:0]    req_tdata,   // [31:0] number
   // result words
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [CHAR_W-1:0]    rsp_tdata,   // [7:0] character
   output logic                 rsp_tlast,
   output logic                 rsp_tuser    // [0] base_invalid
);

   logic [SIZE_W-1:0]  base_size_ff;
   logic [ALPHA_W-1:0] alpha_lo_ff;
   logic [ALPHA_W-1:0] alpha_hi_ff;
   logic               base_ok_ff, base_ok_in;

   state_type          state_ff, state_in;
   logic               neg_ff, neg_in;
   logic [WORD_W-1:0]  mag_ff, mag_in;
   logic [COUNT_W-1:0] nd_ff, nd_in;
   logic [DIGIT_IW-1:0] idx_ff, idx_in;
   logic [DIGIT_W-1:0] digit_ff [DIGIT_BUF];
   logic               dig_we;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_inval_ff, rsp_inval_in;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               slot_free;
   logic [COUNT_W-1:0] nd_next;

   // config registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_size_ff <= '0;
         alpha_lo_ff  <= '0;
         alpha_hi_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_SIZE:  base_size_ff <= csr_data[SIZE_W-1:0];
            CSR_ALPHA_LOW:  alpha_lo_ff  <= csr_data;
            CSR_ALPHA_HIGH: alpha_hi_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // alphabet check: base in 2..16; entries in use must be nonzero, not a sign, and distinct
   always_comb begin
      logic [CHAR_W-1:0] ch [ALPHA_N];
      logic              used [ALPHA_N];
      logic              ok;
      ok = (base_size_ff >= SIZE_W'(MIN_BASE)) && (base_size_ff <= SIZE_W'(MAX_BASE));
      for (int i = 0; i < ALPHA_N; i++) begin
         ch[i]   = alpha_entry(alpha_lo_ff, alpha_hi_ff, DIGIT_W'(i));
         used[i] = SIZE_W'(i) < base_size_ff;
      end
      for (int i = 0; i < ALPHA_N; i++) begin
         if (used[i] && (ch[i] == '0 || ch[i] == CHAR_PLUS || ch[i] == CHAR_MINUS))
            ok = 1'b0;
         for (int j = 0; j < i; j++) begin
            if (used[i] && used[j] && ch[i] == ch[j])
               ok = 1'b0;
         end
      end
      base_ok_in = ok;
   end

   always_ff @(posedge clock) begin
      base_ok_ff <= base_ok_in;
   end

   sitrd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign nd_next    = nd_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      nd_in        = nd_ff;
      idx_in       = idx_ff;
      dig_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_inval_in = rsp_inval_ff;
      div_req.start    = 1'b0;
      div_req.dividend = mag_ff;
      div_req.divisor  = base_size_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               neg_in   = req_tdata[WORD_W-1];
               mag_in   = req_tdata[WORD_W-1] ? ('0 - req_tdata) : req_tdata;
               nd_in    = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!base_ok_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = '0;
                  rsp_last_in  = 1'b1;
                  rsp_inval_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               dig_we = 1'b1;
               nd_in  = nd_next;
               mag_in = div_rsp.quotient;
               if (div_rsp.quotient != '0 && nd_next < COUNT_W'(DIGIT_BUF)) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = div_rsp.quotient;
               end else begin
                  idx_in   = nd_ff[DIGIT_IW-1:0];
                  state_in = neg_ff ? ST_SIGN : ST_EMIT;
               end
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               rsp_inval_in = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = alpha_entry(alpha_lo_ff, alpha_hi_ff, digit_ff[idx_ff]);
               rsp_last_in  = (idx_ff == '0);
               rsp_inval_in = 1'b0;
               if (idx_ff == '0)
                  state_in = ST_IDLE;
               else
                  idx_in = idx_ff - 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         nd_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         nd_ff        <= nd_in;
      end
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      idx_ff       <= idx_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_inval_ff <= rsp_inval_in;
      // digits land least significant first
      if (dig_we)
         digit_ff[nd_ff[DIGIT_IW-1:0]] <= div_rsp.remainder;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_inval_ff;

`ifndef SYNTH
   a_invalid_lone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_inval_ff |-> rsp_last_ff && rsp_char_ff == '0)
      else $error("invalid-base word not a lone empty word");
   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> nd_ff < COUNT_W'(DIGIT_BUF))
      else $error("digit buffer overflow");
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIVIDE)
      else $error("divider result outside divide state");
   a_check_follows_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_CHECK)
      else $error("accepted word did not enter check");
`endif

endmodule
